// ----- hw/rtl/kcs_pkg.sv -----
// Shared constants and types for the keyframe curve sampler.
package kcs_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/kcs_key_ram.sv -----
// Keyframe store: one write port and one registered read port for time and value.
module kcs_key_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [kcs_pkg::ADDR_W-1:0] wr_addr,
  input  logic [kcs_pkg::DATA_W-1:0] wr_time,
  input  logic [kcs_pkg::DATA_W-1:0] wr_value,
  input  logic [kcs_pkg::ADDR_W-1:0] rd_addr,
  output logic [kcs_pkg::DATA_W-1:0] rd_time,
  output logic [kcs_pkg::DATA_W-1:0] rd_value
);

  logic [kcs_pkg::DATA_W-1:0] time_mem  [kcs_pkg::MAX_KEYS];
  logic [kcs_pkg::DATA_W-1:0] value_mem [kcs_pkg::MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= wr_time;
      value_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_time  <= time_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

// ----- hw/rtl/kcs_divider.sv -----
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module kcs_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [2*kcs_pkg::DATA_W-1:0] dividend,
  input  logic [kcs_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [kcs_pkg::DATA_W-1:0]   quotient
);

  logic                         busy;
  logic [kcs_pkg::DATA_W:0]     rem;
  logic [kcs_pkg::DATA_W-1:0]   dq;
  logic [kcs_pkg::DATA_W-1:0]   dsr;
  logic [kcs_pkg::STEP_W-1:0]   steps;
  logic [kcs_pkg::DATA_W:0]     trial;
  logic                         fits;

  // The caller guarantees the quotient fits in 32 bits, so the upper half of
  // the dividend is already below the divisor and seeds the remainder.
  assign trial    = {rem[kcs_pkg::DATA_W-1:0], dq[kcs_pkg::DATA_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= kcs_pkg::STEP_W'(kcs_pkg::DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == kcs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend[2*kcs_pkg::DATA_W-1:kcs_pkg::DATA_W]};
      dq  <= dividend[kcs_pkg::DATA_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dsr}) : trial;
      dq  <= {dq[kcs_pkg::DATA_W-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/keyframe_curve_sampler.sv -----
// Top level of the keyframe curve sampler: sequencer, key scan and interpolation.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | tuser: operation, restart; tdata: key_time, key_value, query_time
//  m_axis   | out | tdata: sample_value; tuser: enough_keys, keys_dropped
//
// An append leaves the sequencer idle and the input stays ready behind it.
// A sample with n keys goes through a fetch, a scan of up to n keys (one key per cycle from
// the single read port of the store), for an interval hit a multiply and a run of the
// bit-serial divider, and then the load of the output register that sends the result beat.
// Reset clears the key count, the drop flag and the output beat; the store keeps its contents.
// A stalled output holds the finished sample and appends are still accepted behind it; a
// further sample is computed and then waits until the beat is taken.
module keyframe_curve_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [31:0] key_time, [63:32] key_value, [95:64] query_time
  input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_value
  output logic [1:0]  m_axis_tuser    // [0] enough_keys, [1] keys_dropped
);

  localparam int DW = kcs_pkg::DATA_W;
  localparam int AW = kcs_pkg::ADDR_W;
  localparam int CW = kcs_pkg::CNT_W;

  kcs_pkg::state_t state, state_next;

  logic          operation;
  logic          restart;
  logic [DW-1:0] key_time;
  logic [DW-1:0] key_value;
  logic [DW-1:0] query_time;

  logic [CW-1:0] key_count;
  logic          overflow_flag;
  logic          store_full;
  logic          in_beat;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_time;
  logic [DW-1:0] rd_value;

  logic [DW-1:0]   q_time;
  logic [AW-1:0]   scan_idx;
  logic [AW-1:0]   last_idx;
  logic [DW-1:0]   prev_time;
  logic [DW-1:0]   prev_val;
  logic [DW-1:0]   lerp_y0;
  logic            lerp_neg;
  logic [DW-1:0]   lerp_mag;
  logic [DW-1:0]   lerp_t;
  logic [DW-1:0]   lerp_d;
  logic [2*DW-1:0] product;
  logic [DW-1:0]   res_val;
  logic            res_enough;

  logic            q_le;
  logic [DW:0]     dy;
  logic [DW-1:0]   dy_mag;
  logic [DW+1:0]   sum;
  logic [DW-1:0]   sum_sat;

  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   quotient;
  logic            out_free;

  assign operation  = s_axis_tuser[0];
  assign restart    = s_axis_tuser[1];
  assign key_time   = s_axis_tdata[DW-1:0];
  assign key_value  = s_axis_tdata[2*DW-1:DW];
  assign query_time = s_axis_tdata[3*DW-1:2*DW];

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign store_full = key_count == CW'(kcs_pkg::MAX_KEYS);
  assign wr_en      = in_beat && (operation == kcs_pkg::OP_APPEND) && (restart || !store_full);
  assign wr_addr    = restart ? '0 : key_count[AW-1:0];
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  kcs_key_ram u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_time  (key_time),
    .wr_value (key_value),
    .rd_addr  (rd_addr),
    .rd_time  (rd_time),
    .rd_value (rd_value)
  );

  kcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (lerp_d),
    .done     (div_done),
    .quotient (quotient)
  );

  // Interval arithmetic on the key being scanned and the one before it.
  assign q_le   = $signed(q_time) <= $signed(rd_time);
  assign dy     = {rd_value[DW-1], rd_value} - {prev_val[DW-1], prev_val};
  assign dy_mag = dy[DW] ? DW'(-dy) : dy[DW-1:0];

  // The quotient never exceeds |y1 - y0|, so the saturation never bites.
  assign sum = lerp_neg ? ({{2{lerp_y0[DW-1]}}, lerp_y0} - {2'b00, quotient})
                        : ({{2{lerp_y0[DW-1]}}, lerp_y0} + {2'b00, quotient});
  always_comb begin
    if ($signed(sum) > $signed({3'b000, {(DW-1){1'b1}}})) begin
      sum_sat = {1'b0, {(DW-1){1'b1}}};
    end else if ($signed(sum) < $signed({3'b111, {(DW-1){1'b0}}})) begin
      sum_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sum_sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_addr       = scan_idx;
    div_start     = 1'b0;
    case (state)
      kcs_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && operation == kcs_pkg::OP_SAMPLE) begin
          state_next = (key_count < CW'(2)) ? kcs_pkg::ST_DONE : kcs_pkg::ST_FETCH;
        end
      end
      kcs_pkg::ST_FETCH: begin
        rd_addr    = '0;
        state_next = kcs_pkg::ST_SCAN;
      end
      kcs_pkg::ST_SCAN: begin
        // Prefetch the next key while the current one is compared.
        rd_addr = scan_idx + 1'b1;
        if (q_le) begin
          state_next = (scan_idx == '0) ? kcs_pkg::ST_DONE : kcs_pkg::ST_MUL;
        end else if (scan_idx == last_idx) begin
          state_next = kcs_pkg::ST_DONE;
        end
      end
      kcs_pkg::ST_MUL: begin
        state_next = kcs_pkg::ST_DIV_START;
      end
      kcs_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = kcs_pkg::ST_DIV_WAIT;
      end
      kcs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = kcs_pkg::ST_DONE;
        end
      end
      kcs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = kcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Key count and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (in_beat && operation == kcs_pkg::OP_APPEND) begin
      if (restart) begin
        key_count     <= CW'(1);
        overflow_flag <= 1'b0;
      end else if (store_full) begin
        overflow_flag <= 1'b1;
      end else begin
        key_count <= key_count + 1'b1;
      end
    end
  end

  // Sample datapath.
  always_ff @(posedge clk) begin
    case (state)
      kcs_pkg::ST_IDLE: begin
        q_time     <= query_time;
        scan_idx   <= '0;
        last_idx   <= AW'(key_count - 1'b1);
        res_val    <= '0;
        res_enough <= key_count >= CW'(2);
      end
      kcs_pkg::ST_SCAN: begin
        if (q_le) begin
          res_val  <= rd_value;
          lerp_y0  <= prev_val;
          lerp_neg <= dy[DW];
          lerp_mag <= dy_mag;
          lerp_t   <= q_time - prev_time;
          lerp_d   <= rd_time - prev_time;
        end else begin
          // Past the last key the last value stands.
          res_val   <= rd_value;
          prev_time <= rd_time;
          prev_val  <= rd_value;
          scan_idx  <= scan_idx + 1'b1;
        end
      end
      kcs_pkg::ST_MUL: begin
        product <= lerp_mag * lerp_t;
      end
      kcs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          res_val <= sum_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == kcs_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kcs_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= res_val;
      m_axis_tuser <= {overflow_flag, res_enough};
    end
  end

endmodule

// ----- hw/rtl/kcs_checker.sv -----
// Port-level checks for the keyframe curve sampler, bound to its top level.
module kcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A result beat that is not taken holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // A sample keeps the input closed for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == kcs_pkg::OP_SAMPLE |=>
      !s_axis_tready)
    else $error("input ready right after a sample beat");

  // An append leaves the input ready in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == kcs_pkg::OP_APPEND |=>
      s_axis_tready)
    else $error("input not ready after an append beat");

  // With too few keys the value is zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("nonzero value without enough keys");

  // No result beat appears straight out of reset.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

endmodule

bind keyframe_curve_sampler kcs_checker u_kcs_checker (.*);
